[design/lru_page_replacement_macros.svh]
// Assertion macros for the checker file of the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LRUPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("LRU page replacement: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("LRU page replacement: next-cycle check failed");

`endif

[design/lrupr_pkg.sv]
// Types and constants of the LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package lrupr_pkg;

  localparam int FramesDefault = 8;
  localparam int CfgW          = 4;
  localparam int PageW         = 8;
  localparam int CountW        = 32;

  localparam logic [CfgW-1:0]   FrameCountReset = 4'd8;
  localparam logic [CountW-1:0] CountMax        = '1;

  typedef struct packed {
    logic [PageW-1:0] page;
    logic             string_start;
  } in_req_t;

  typedef struct packed {
    logic              fault;
    logic [2:0]        frame_index;
    logic [CountW-1:0] fault_total;
  } out_rsp_t;

endpackage
`default_nettype wire

[design/lru_page_replacement.sv]
// A request passes IDLE, SCAN (one read per frame in use), DRAIN and UPDATE to its result.
// One request at a time; the serial frame scan through the page RAM read port
//   (one frame per cycle, one shared compare) sets the pace, and UPDATE waits for out_free.
// The result sits in an output register, so a new request is taken while it waits.
// Reset (rst_ni low, asynchronous): all frames empty, frame 0 oldest, fault count zero,
//   frame_count = 8. Page RAM contents are not cleared; valid bits mask them.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_replacement #(
  parameter int FRAMES = lrupr_pkg::FramesDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write: frame_count
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [lrupr_pkg::CfgW-1:0] cfg_data_i,
  // page reference requests
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire lrupr_pkg::in_req_t        in_data_i,
  // results
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output lrupr_pkg::out_rsp_t            out_data_o
);

  // Frame index and recency rank share one width: ranks are 0..FRAMES-1.
  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAMES - 1);

  // Sequencer: IDLE takes a request, SCAN issues one RAM read per frame,
  // DRAIN checks the last read, UPDATE moves ranks, loads on a miss, posts the result.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [lrupr_pkg::CfgW-1:0]   fc_q, fc_d;
  logic [lrupr_pkg::PageW-1:0]  page_q, page_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [IdxW-1:0]              used_m1_q, used_m1_d;
  logic                         chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]              chk_idx_q, chk_idx_d;
  logic                         found_q, found_d;
  logic [IdxW-1:0]              hit_q, hit_d;
  logic                         empty_q, empty_d;
  logic                         oldest_vld_q, oldest_vld_d;
  logic [IdxW-1:0]              oldest_q, oldest_d;
  logic [IdxW-1:0]              victim_q, victim_d;
  logic [FRAMES-1:0]            valid_q, valid_d;
  logic [IdxW-1:0]              rank_q [FRAMES];
  logic [IdxW-1:0]              rank_d [FRAMES];
  logic [lrupr_pkg::CountW-1:0] fault_cnt_q, fault_cnt_d;
  logic                         out_vld_q, out_vld_d;
  lrupr_pkg::out_rsp_t          out_q, out_d;

  // Shared compare datapath
  logic [lrupr_pkg::PageW-1:0]  rd_page;
  logic                         chk_valid;
  logic [IdxW-1:0]              chk_rank;
  logic [IdxW-1:0]              used_m1_cfg;
  logic [IdxW-1:0]              tgt;
  logic [IdxW-1:0]              tgt_rank;
  logic [lrupr_pkg::CountW-1:0] cnt_next;
  logic                         ram_we;
  logic                         out_free;

  lrupr_ram #(
    .Width (lrupr_pkg::PageW),
    .Depth (FRAMES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt),
    .wdata_i (page_q),
    .raddr_i (idx_q),
    .rdata_o (rd_page)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign chk_valid = valid_q[chk_idx_q];
  assign chk_rank  = rank_q[chk_idx_q];
  assign out_free  = !out_vld_q || out_ready_i;

  // Frame count 0 behaves as 1, anything above FRAMES as FRAMES.
  always_comb begin
    if (fc_q == '0) begin
      used_m1_cfg = '0;
    end else if (int'(fc_q) > FRAMES) begin
      used_m1_cfg = LastIdx;
    end else begin
      used_m1_cfg = IdxW'(fc_q - 4'd1);
    end
  end

  // Hit frame wins; otherwise the victim picked during the scan.
  assign tgt      = found_q ? hit_q : victim_q;
  assign tgt_rank = rank_q[tgt];
  assign cnt_next = (found_q || fault_cnt_q == lrupr_pkg::CountMax) ? fault_cnt_q
                                                                    : fault_cnt_q + 1'b1;
  assign ram_we   = (state_q == ST_UPDATE) && out_free && !found_q;

  always_comb begin
    state_d      = state_q;
    fc_d         = fc_q;
    page_d       = page_q;
    idx_d        = idx_q;
    used_m1_d    = used_m1_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    hit_d        = hit_q;
    empty_d      = empty_q;
    oldest_vld_d = oldest_vld_q;
    oldest_d     = oldest_q;
    victim_d     = victim_q;
    valid_d      = valid_q;
    rank_d       = rank_q;
    fault_cnt_d  = fault_cnt_q;
    out_vld_d    = out_vld_q;
    out_d        = out_q;

    if (cfg_valid_i) begin
      fc_d = cfg_data_i;
    end

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    // One frame checked per cycle, one read behind the address.
    // Lowest matching index is the hit; first empty frame, else oldest rank, is the victim.
    if (chk_vld_q) begin
      if (!found_q && chk_valid && rd_page == page_q) begin
        found_d = 1'b1;
        hit_d   = chk_idx_q;
      end
      if (!chk_valid) begin
        if (!empty_q) begin
          empty_d  = 1'b1;
          victim_d = chk_idx_q;
        end
      end else if (!empty_q && (!oldest_vld_q || chk_rank > oldest_q)) begin
        oldest_vld_d = 1'b1;
        oldest_d     = chk_rank;
        victim_d     = chk_idx_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          page_d       = in_data_i.page;
          used_m1_d    = used_m1_cfg;
          idx_d        = '0;
          found_d      = 1'b0;
          empty_d      = 1'b0;
          oldest_vld_d = 1'b0;
          victim_d     = '0;
          // String start: empty frames, restore index-order ranks, clear the count.
          if (in_data_i.string_start) begin
            valid_d     = '0;
            fault_cnt_d = '0;
            for (int i = 0; i < FRAMES; i++) begin
              rank_d[i] = IdxW'(FRAMES - 1 - i);
            end
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        if (idx_q == used_m1_q) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        chk_vld_d = 1'b0;
        state_d   = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Holds here while the previous result is still unread.
        if (out_free) begin
          for (int i = 0; i < FRAMES; i++) begin
            if (rank_q[i] < tgt_rank) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
          rank_d[tgt] = '0;
          if (!found_q) begin
            valid_d[tgt] = 1'b1;
          end
          fault_cnt_d       = cnt_next;
          out_vld_d         = 1'b1;
          out_d.fault       = !found_q;
          out_d.frame_index = 3'(tgt);
          out_d.fault_total = cnt_next;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fc_q        <= lrupr_pkg::FrameCountReset;
      chk_vld_q   <= 1'b0;
      valid_q     <= '0;
      fault_cnt_q <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= IdxW'(FRAMES - 1 - i);
      end
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      chk_vld_q   <= chk_vld_d;
      valid_q     <= valid_d;
      fault_cnt_q <= fault_cnt_d;
      out_vld_q   <= out_vld_d;
      rank_q      <= rank_d;
    end
  end

  // Scan bookkeeping and result payload
  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    idx_q        <= idx_d;
    used_m1_q    <= used_m1_d;
    chk_idx_q    <= chk_idx_d;
    found_q      <= found_d;
    hit_q        <= hit_d;
    empty_q      <= empty_d;
    oldest_vld_q <= oldest_vld_d;
    oldest_q     <= oldest_d;
    victim_q     <= victim_d;
    out_q        <= out_d;
  end

endmodule
`default_nettype wire

[design/lrupr_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lrupr_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[design/lrupr_chk.sv]
// Port-level checker for the LRU page replacement block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_page_replacement_macros.svh"
module lrupr_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire lrupr_pkg::out_rsp_t        out_data_o
);

  // A stalled result holds.
  `LRUPR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                     out_valid_o && $stable(out_data_o))

  // One request at a time: busy right after acceptance.
  `LRUPR_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)

  // The scan lies between acceptance and result, so no result appears right after a request.
  `LRUPR_ASSERT_NEXT(a_no_early_rsp, in_valid_i && in_ready_o, !$rose(out_valid_o))

  // A fault is counted until the count saturates; its reported total is never zero.
  `LRUPR_ASSERT_IMPL(a_fault_counted, out_valid_o && out_data_o.fault,
                     out_data_o.fault_total != '0)

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
